// ===== hw/rtl/rsep_pkg.sv =====
// Shared types and constants for the reverb send envelope / predelay unit.
// No dependencies; used by rsep_predelay and reverb_send_envelope_predelay_unit.
package rsep_pkg;

  // Sequencer states, one word in flight at a time
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_HP,
    ST_MUL3,
    ST_DONE
  } seq_state_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HP_COEF   = 2'd0,
    CFG_REL_COEF  = 2'd1,
    CFG_PREDELAY  = 2'd2,
    CFG_SEND_GAIN = 2'd3
  } cfg_index_t;

  // Register reset values
  localparam logic [15:0] HP_COEF_RESET   = 16'd63000;
  localparam logic [15:0] REL_COEF_RESET  = 16'd65511;
  localparam logic [11:0] PREDELAY_RESET  = 12'd576;
  localparam logic [15:0] SEND_GAIN_RESET = 16'd0;

  // Q16 constants: 1.35 and 0.72, plus rounding offset
  localparam int ONE_35_Q16  = 88474;
  localparam int ZERO_72_Q16 = 47186;
  localparam int ROUND_Q16   = 32768;

  // Predelay memory control from the sequencer
  typedef struct packed {
    logic rd_en;   // read the tap entry
    logic wr_en;   // write the new sample and advance
  } delay_ctrl_t;

  // Qualifiers registered with the tap read
  typedef struct packed {
    logic written; // tap entry has been written since reset
    logic same;    // zero predelay: tap is the entry being written
  } delay_stat_t;

endpackage

// ===== hw/rtl/rsep_predelay.sv =====
// Circular predelay memory with write pointer, fill count and tap address.
// Depends on rsep_pkg (delay_ctrl_t, delay_stat_t).
module rsep_predelay #(
  parameter int DELAY_DEPTH = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rsep_pkg::delay_ctrl_t         ctrl,
  input  logic [11:0]                   predelay,
  input  logic signed [SAMPLE_BITS-1:0] wr_data,
  output logic signed [SAMPLE_BITS-1:0] rd_data,
  output rsep_pkg::delay_stat_t         stat
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int PW = (AW > 12) ? AW : 12;

  logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] fill;
  logic [PW-1:0] pre_w;
  logic [AW-1:0] pre_c;
  logic [AW:0]   rd_wide;
  logic [AW-1:0] rd_addr;

  // Clamp predelay below the depth
  always_comb begin
    pre_w = PW'(predelay);
    if (pre_w > PW'(DELAY_DEPTH - 1)) begin
      pre_c = AW'(DELAY_DEPTH - 1);
    end else begin
      pre_c = AW'(pre_w);
    end
  end

  // Tap address, wrapping for any depth
  always_comb begin
    if (wp >= pre_c) begin
      rd_wide = {1'b0, wp} - {1'b0, pre_c};
    end else begin
      rd_wide = {1'b0, wp} + (AW+1)'(DELAY_DEPTH) - {1'b0, pre_c};
    end
    rd_addr = rd_wide[AW-1:0];
  end

  // Write pointer and fill count; the count stands in for clearing the array
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (ctrl.wr_en) begin
      wp <= (wp == AW'(DELAY_DEPTH - 1)) ? '0 : wp + 1'b1;
      if (fill != AW'(DELAY_DEPTH - 1)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wp] <= wr_data;
    end
  end

  // Registered tap read with its qualifiers
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else if (ctrl.rd_en) begin
      stat.written <= (pre_c <= fill);
      stat.same    <= (pre_c == '0);
    end
  end

endmodule

// ===== hw/rtl/reverb_send_envelope_predelay_unit.sv =====
// Top level: envelope follower, high-pass and predelay send for one stereo word.
// Depends on rsep_pkg and rsep_predelay.
//
//   channel | signals                                   | word
//   input   | in_valid / in_ready                       | dry_left, dry_right, note_on
//   output  | out_valid / out_ready                     | envelope_level, wet_send, age_samples
//   config  | cfg_write, cfg_index, cfg_data            | one register per write
//
// Sequencing: the sequencer walks each word through three registered multiply
// steps and the predelay memory's read-then-write, one word at a time; a new
// word is accepted only once the last one has left its final step.
// Output register: the next word is accepted while a result waits; a word stalls
// in its last step only if the previous result is still held.
// Reset: synchronous; no clearing pass, a fill count makes unwritten taps read zero.
module reverb_send_envelope_predelay_unit #(
  parameter int DELAY_DEPTH = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] dry_left,
  input  logic signed [SAMPLE_BITS-1:0] dry_right,
  input  logic                          note_on,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-2:0]        envelope_level,
  output logic signed [SAMPLE_BITS-1:0] wet_send,
  output logic [31:0]                   age_samples,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam logic signed [16:0] K072 = 17'(rsep_pkg::ZERO_72_Q16);
  localparam logic [16:0]        K135 = 17'(rsep_pkg::ONE_35_Q16);

  // Configuration registers
  logic [15:0] hp_coef;
  logic [15:0] rel_coef;
  logic [11:0] predelay;
  logic [15:0] send_gain;

  // Sequencer
  rsep_pkg::seq_state_t state, state_next;
  rsep_pkg::delay_ctrl_t dl_ctrl;
  rsep_pkg::delay_stat_t dl_stat;
  logic load_out;

  // Word and filter state
  logic signed [SB-1:0] l_q, r_q;
  logic                 note_q;
  logic [SB-1:0]        env;
  logic signed [SB-1:0] hp_x, hp_y;
  logic [31:0]          age_cnt;

  // Pipeline registers
  logic [SB-1:0]        mag_q;
  logic [SB+15:0]       dec_prod;
  logic signed [SB+16:0] send_prod;
  logic signed [SB+18:0] hp_prod;
  logic signed [SB-1:0] hp_q;
  logic signed [SB+16:0] wet_prod;
  logic [SB+16:0]       lvl_prod;

  // Combinational datapath
  logic signed [SB:0]    sum_lr;
  logic signed [SB-1:0]  mono;
  logic [SB-1:0]         mag;
  logic [SB-1:0]         decayed;
  logic signed [SB+17:0] send_rnd;
  logic signed [SB-1:0]  send;
  logic signed [SB+1:0]  hp_diff;
  logic signed [SB+19:0] hp_rnd;
  logic signed [SB+3:0]  hp_q16;
  logic signed [SB-1:0]  hp_sat;
  logic signed [SB-1:0]  rd_data;
  logic signed [SB-1:0]  wet_op;
  logic signed [SB+17:0] wet_rnd;
  logic signed [SB+1:0]  wet_q16;
  logic signed [SB-1:0]  wet_sat;
  logic [SB+17:0]        lvl_rnd;
  logic [SB+1:0]         lvl_q16;
  logic [SB-2:0]         lvl_sat;
  logic [31:0]           age_now;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hp_coef   <= rsep_pkg::HP_COEF_RESET;
      rel_coef  <= rsep_pkg::REL_COEF_RESET;
      predelay  <= rsep_pkg::PREDELAY_RESET;
      send_gain <= rsep_pkg::SEND_GAIN_RESET;
    end else if (cfg_write) begin
      unique case (rsep_pkg::cfg_index_t'(cfg_index))
        rsep_pkg::CFG_HP_COEF:   hp_coef   <= cfg_data;
        rsep_pkg::CFG_REL_COEF:  rel_coef  <= cfg_data;
        rsep_pkg::CFG_PREDELAY:  predelay  <= cfg_data[11:0];
        rsep_pkg::CFG_SEND_GAIN: send_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rsep_pkg::ST_IDLE: if (in_valid) state_next = rsep_pkg::ST_MUL1;
      rsep_pkg::ST_MUL1: state_next = rsep_pkg::ST_MUL2;
      rsep_pkg::ST_MUL2: state_next = rsep_pkg::ST_HP;
      rsep_pkg::ST_HP:   state_next = rsep_pkg::ST_MUL3;
      rsep_pkg::ST_MUL3: state_next = rsep_pkg::ST_DONE;
      rsep_pkg::ST_DONE: if (!out_valid || out_ready) state_next = rsep_pkg::ST_IDLE;
      default:           state_next = rsep_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    dl_ctrl       = '0;
    load_out      = 1'b0;
    unique case (state)
      rsep_pkg::ST_IDLE: in_ready = 1'b1;
      rsep_pkg::ST_MUL1: dl_ctrl.rd_en = 1'b1;
      rsep_pkg::ST_HP:   dl_ctrl.wr_en = 1'b1;
      rsep_pkg::ST_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsep_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Mono mix and magnitude
  always_comb begin
    sum_lr = l_q + r_q;
    mono   = sum_lr[SB:1];
    mag    = mono[SB-1] ? (~mono + 1'b1) : mono;
  end

  // Envelope decay and 0.72 send rounding
  always_comb begin
    decayed  = dec_prod[SB+15:16];
    send_rnd = send_prod + (SB+18)'(rsep_pkg::ROUND_Q16);
    send     = send_rnd[SB+15:16];
    hp_diff  = hp_y + send - hp_x;
  end

  // High-pass rounding and saturation
  always_comb begin
    hp_rnd = hp_prod + (SB+20)'(rsep_pkg::ROUND_Q16);
    hp_q16 = hp_rnd[SB+19:16];
    if ((&hp_q16[SB+3:SB-1]) || !(|hp_q16[SB+3:SB-1])) begin
      hp_sat = hp_q16[SB-1:0];
    end else if (hp_q16[SB+3]) begin
      hp_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      hp_sat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  // Tap select: same-step forward, unwritten entry reads zero
  always_comb begin
    if (dl_stat.same) begin
      wet_op = hp_q;
    end else if (dl_stat.written) begin
      wet_op = rd_data;
    end else begin
      wet_op = '0;
    end
  end

  // Send gain rounding and saturation
  always_comb begin
    wet_rnd = wet_prod + (SB+18)'(rsep_pkg::ROUND_Q16);
    wet_q16 = wet_rnd[SB+17:16];
    if ((&wet_q16[SB+1:SB-1]) || !(|wet_q16[SB+1:SB-1])) begin
      wet_sat = wet_q16[SB-1:0];
    end else if (wet_q16[SB+1]) begin
      wet_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      wet_sat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  // Level scaling clamp and age
  always_comb begin
    lvl_rnd = lvl_prod + (SB+18)'(rsep_pkg::ROUND_Q16);
    lvl_q16 = lvl_rnd[SB+17:16];
    if (|lvl_q16[SB+1:SB-1]) begin
      lvl_sat = '1;
    end else begin
      lvl_sat = lvl_q16[SB-2:0];
    end
    age_now = note_q ? '0 : age_cnt;
  end

  // Datapath registers, stepped by the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      rsep_pkg::ST_IDLE: begin
        if (in_valid) begin
          l_q    <= dry_left;
          r_q    <= dry_right;
          note_q <= note_on;
        end
      end
      rsep_pkg::ST_MUL1: begin
        mag_q     <= mag;
        dec_prod  <= env * rel_coef;
        send_prod <= mono * K072;
      end
      rsep_pkg::ST_MUL2: begin
        hp_prod <= hp_diff * $signed({1'b0, hp_coef});
      end
      rsep_pkg::ST_HP: begin
        hp_q <= hp_sat;
      end
      rsep_pkg::ST_MUL3: begin
        wet_prod <= wet_op * $signed({1'b0, send_gain});
        lvl_prod <= env * K135;
      end
      default: ;
    endcase
  end

  // Filter and envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      env  <= '0;
      hp_x <= '0;
      hp_y <= '0;
    end else begin
      if (state == rsep_pkg::ST_MUL2) begin
        env  <= (mag_q > decayed) ? mag_q : decayed;
        hp_x <= send;
      end
      if (state == rsep_pkg::ST_HP) begin
        hp_y <= hp_sat;
      end
    end
  end

  // Output register and saturating age count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      age_cnt   <= '0;
    end else if (load_out) begin
      out_valid <= 1'b1;
      age_cnt   <= (age_now == '1) ? age_now : age_now + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      envelope_level <= lvl_sat;
      wet_send       <= wet_sat;
      age_samples    <= age_now;
    end
  end

  // Predelay memory
  rsep_predelay #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_predelay (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (dl_ctrl),
    .predelay (predelay),
    .wr_data  (hp_sat),
    .rd_data  (rd_data),
    .stat     (dl_stat)
  );

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == rsep_pkg::ST_MUL1)
    else $error("accepted word did not start the sequence");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    dl_ctrl.rd_en |-> ##2 dl_ctrl.wr_en)
    else $error("predelay write not two cycles after tap read");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && state == rsep_pkg::ST_IDLE)
    else $error("result load did not raise out_valid");

  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    dl_ctrl.wr_en |-> !in_ready && !load_out)
    else $error("accept or load during memory write");

endmodule
